### rtl/crma_pkg.sv
// ----------------------------------------------------------------------------
// crma_pkg: shared types and constants for the cursor row mask aligner
// Field widths, register indexes, reset values and the control bundle that
// drives the bit placement stage.
// ----------------------------------------------------------------------------
package crma_pkg;

    // cursor geometry and field widths
    localparam int CURSOR_SIZE = 16;
    localparam int SRC_W       = 16;
    localparam int POS_W       = 16;
    localparam int RES_W       = 15;
    localparam int OUT_W       = 24;
    localparam int SHIFT_W     = 5;
    localparam int COL_W       = 4;

    // reset resolution
    localparam logic [RES_W-1:0] WIDE_RESET = 15'd640;
    localparam logic [RES_W-1:0] HIGH_RESET = 15'd480;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_WIDE = 1'b0,
        REG_HIGH = 1'b1
    } t_reg_idx;

    // bit placement control: right shift of the source row, first and last
    // visible source column
    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic [COL_W-1:0]   col_lo;
        logic [COL_W-1:0]   col_hi;
    } t_place_ctl;

endpackage

### rtl/crma_place.sv
// ----------------------------------------------------------------------------
// crma_place: cursor row bit placement
// Drops source columns outside the visible span and shifts the mask and
// image row into three video bytes, bit 23 being the leftmost pixel.
// ----------------------------------------------------------------------------
module crma_place (
    input  crma_pkg::t_place_ctl              i_ctl,
    input  logic [crma_pkg::SRC_W-1:0]        i_mask_row,
    input  logic [crma_pkg::SRC_W-1:0]        i_image_row,
    output logic [crma_pkg::OUT_W-1:0]        o_mask_bytes,
    output logic [crma_pkg::OUT_W-1:0]        o_image_bytes
);

    logic [crma_pkg::SRC_W-1:0]                  keep;
    logic [4:0]                                  hi_amt;
    logic [crma_pkg::SRC_W-1:0]                  mask_vis;
    logic [crma_pkg::SRC_W-1:0]                  image_vis;
    logic [crma_pkg::SRC_W+crma_pkg::OUT_W-2:0] mask_wide;
    logic [crma_pkg::SRC_W+crma_pkg::OUT_W-2:0] image_wide;

    // visible column window, column 0 is bit 15
    always_comb begin
        hi_amt    = {1'b0, i_ctl.col_hi} + 5'd1;
        keep      = (16'hFFFF >> i_ctl.col_lo) & ~(16'hFFFF >> hi_amt);
        mask_vis  = i_mask_row & keep;
        image_vis = i_image_row & mask_vis;
    end

    // a shift of 15 puts source bit 15 at byte bit 23
    always_comb begin
        mask_wide     = {mask_vis, 23'd0} >> i_ctl.shift;
        image_wide    = {image_vis, 23'd0} >> i_ctl.shift;
        o_mask_bytes  = mask_wide[crma_pkg::OUT_W-1:0];
        o_image_bytes = image_wide[crma_pkg::OUT_W-1:0];
    end

endmodule

### rtl/cursor_row_mask_aligner.sv
// Pipeline: three register stages (bounds, clip, place) lie between a taken request
// and its result on the result ports (o_valid).
// Throughput: one request per cycle, every cycle; busy is high in reset and in
// the first cycle after it, low otherwise.
// The result stands for one cycle only; the receiver cannot stall it.
// Reset (synchronous, active low) empties the pipeline and loads 640x480.
// ----------------------------------------------------------------------------
// cursor_row_mask_aligner: clip a 16x16 cursor and align one row to bytes
// Checks size and position, reports the saved screen area and places the
// mask and image bits of one source row into three video bytes.
// ----------------------------------------------------------------------------
module cursor_row_mask_aligner (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            start,
    output logic                            busy,
    input  logic [crma_pkg::POS_W-1:0]      i_pos_x,
    input  logic [crma_pkg::POS_W-1:0]      i_pos_y,
    input  logic [15:0]                     i_shape_width,
    input  logic [15:0]                     i_shape_height,
    input  logic [3:0]                      i_row_number,
    input  logic [crma_pkg::SRC_W-1:0]      i_cursor_mask_row,
    input  logic [crma_pkg::SRC_W-1:0]      i_cursor_image_row,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [0:0]                      i_cfg_idx,
    input  logic [crma_pkg::RES_W-1:0]      i_cfg_data,
    // result channel
    output logic                            o_valid,
    output logic                            o_accepted,
    output logic                            o_row_shown,
    output logic [3:0]                      o_dest_row,
    output logic [crma_pkg::OUT_W-1:0]      o_mask_out,
    output logic [crma_pkg::OUT_W-1:0]      o_image_out,
    output logic [crma_pkg::RES_W-1:0]      o_clip_left,
    output logic [crma_pkg::RES_W-1:0]      o_clip_top,
    output logic [11:0]                     o_first_column,
    output logic [1:0]                      o_columns_used,
    output logic [4:0]                      o_rows_used
);

    // configuration and busy
    logic [crma_pkg::RES_W-1:0] r_wide;
    logic [crma_pkg::RES_W-1:0] r_high;
    logic                       r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide <= crma_pkg::WIDE_RESET;
            r_high <= crma_pkg::HIGH_RESET;
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                case (crma_pkg::t_reg_idx'(i_cfg_idx))
                    crma_pkg::REG_WIDE: r_wide <= i_cfg_data;
                    crma_pkg::REG_HIGH: r_high <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign busy = r_busy;

    // ---------------- stage 1: bounds checks and edge clipping ----------------
    logic signed [16:0] x_ext, y_ext, xres_ext, yres_ext, x_end, y_end;
    logic               take;
    logic               n_ok1;
    logic [14:0]        n_left, n_top;
    logic signed [16:0] n_right, n_bottom;
    logic [4:0]         n_shift;
    logic [3:0]         n_col_lo, n_src0;

    always_comb begin
        take     = start && !r_busy;
        x_ext    = {i_pos_x[15], i_pos_x};
        y_ext    = {i_pos_y[15], i_pos_y};
        xres_ext = {2'b00, r_wide};
        yres_ext = {2'b00, r_high};
        x_end    = x_ext + 17'sd15;
        y_end    = y_ext + 17'sd15;
        n_ok1    = (i_shape_width == 16'(crma_pkg::CURSOR_SIZE)) &&
                   (i_shape_height == 16'(crma_pkg::CURSOR_SIZE)) &&
                   (x_ext >= -17'sd15) && (x_ext < xres_ext) &&
                   (y_ext >= -17'sd15) && (y_ext < yres_ext);
        n_left   = i_pos_x[15] ? 15'd0 : i_pos_x[14:0];
        n_top    = i_pos_y[15] ? 15'd0 : i_pos_y[14:0];
        n_right  = (x_end >= xres_ext) ? (xres_ext - 17'sd1) : x_end;
        n_bottom = (y_end >= yres_ext) ? (yres_ext - 17'sd1) : y_end;
        // left of column 0 the row moves left, else right by x within its byte
        n_shift  = i_pos_x[15] ? x_end[4:0] : (5'd15 + {2'b00, i_pos_x[2:0]});
        n_col_lo = i_pos_x[15] ? (4'd0 - i_pos_x[3:0]) : 4'd0;
        n_src0   = i_pos_y[15] ? (4'd0 - i_pos_y[3:0]) : 4'd0;
    end

    logic                       r1_valid, r1_ok;
    logic [14:0]                r1_left, r1_top;
    logic signed [16:0]         r1_right, r1_bottom;
    logic [3:0]                 r1_x_lo, r1_row, r1_src0, r1_col_lo;
    logic [4:0]                 r1_shift;
    logic [crma_pkg::SRC_W-1:0] r1_mask, r1_image;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= take;
        end
        r1_ok     <= n_ok1;
        r1_left   <= n_left;
        r1_top    <= n_top;
        r1_right  <= n_right;
        r1_bottom <= n_bottom;
        r1_x_lo   <= i_pos_x[3:0];
        r1_row    <= i_row_number;
        r1_src0   <= n_src0;
        r1_col_lo <= n_col_lo;
        r1_shift  <= n_shift;
        r1_mask   <= i_cursor_mask_row;
        r1_image  <= i_cursor_image_row;
    end

    // ---------------- stage 2: saved area and row window ----------------
    // span of at most 16 pixels covers at most three bytes and 16 rows
    logic               n_ok2, n_shown;
    logic signed [16:0] rows_full;
    logic [4:0]         n_rows, row_end;
    logic [1:0]         n_bytes;
    logic [3:0]         n_col_hi, n_dest;

    always_comb begin
        n_ok2     = r1_ok && (r1_right >= $signed({2'b00, r1_left})) &&
                    (r1_bottom >= $signed({2'b00, r1_top}));
        rows_full = r1_bottom - $signed({2'b00, r1_top}) + 17'sd1;
        n_rows    = rows_full[4:0];
        n_bytes   = 2'(r1_right[14:3] - r1_left[14:3] + 12'd1);
        n_col_hi  = r1_right[3:0] - r1_x_lo;
        row_end   = {1'b0, r1_src0} + n_rows;
        n_shown   = (r1_row >= r1_src0) && ({1'b0, r1_row} < row_end);
        n_dest    = r1_row - r1_src0;
    end

    logic                       r2_valid, r2_ok, r2_shown;
    logic [3:0]                 r2_dest;
    logic [14:0]                r2_left, r2_top;
    logic [1:0]                 r2_bytes;
    logic [4:0]                 r2_rows;
    crma_pkg::t_place_ctl       r2_ctl;
    logic [crma_pkg::SRC_W-1:0] r2_mask, r2_image;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_ok         <= n_ok2;
        r2_shown      <= n_shown;
        r2_dest       <= n_dest;
        r2_left       <= r1_left;
        r2_top        <= r1_top;
        r2_bytes      <= n_bytes;
        r2_rows       <= n_rows;
        r2_ctl.shift  <= r1_shift;
        r2_ctl.col_lo <= r1_col_lo;
        r2_ctl.col_hi <= n_col_hi;
        r2_mask       <= r1_mask;
        r2_image      <= r1_image;
    end

    // ---------------- stage 3: bit placement and result register ----------------
    logic [crma_pkg::OUT_W-1:0] place_mask, place_image;
    logic                       show;

    crma_place u_place (
        .i_ctl         (r2_ctl),
        .i_mask_row    (r2_mask),
        .i_image_row   (r2_image),
        .o_mask_bytes  (place_mask),
        .o_image_bytes (place_image)
    );

    assign show = r2_ok && r2_shown;

    logic                       r_valid, r_accepted, r_row_shown;
    logic [3:0]                 r_dest_row;
    logic [crma_pkg::OUT_W-1:0] r_mask_out, r_image_out;
    logic [14:0]                r_clip_left, r_clip_top;
    logic [11:0]                r_first_column;
    logic [1:0]                 r_columns_used;
    logic [4:0]                 r_rows_used;

    // refused calls report all zero, hidden rows zero bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r2_valid;
        end
        r_accepted     <= r2_ok;
        r_row_shown    <= show;
        r_dest_row     <= show ? r2_dest : 4'd0;
        r_mask_out     <= show ? place_mask : '0;
        r_image_out    <= show ? place_image : '0;
        r_clip_left    <= r2_ok ? r2_left : 15'd0;
        r_clip_top     <= r2_ok ? r2_top : 15'd0;
        r_first_column <= r2_ok ? r2_left[14:3] : 12'd0;
        r_columns_used <= r2_ok ? r2_bytes : 2'd0;
        r_rows_used    <= r2_ok ? r2_rows : 5'd0;
    end

    assign o_valid        = r_valid;
    assign o_accepted     = r_accepted;
    assign o_row_shown    = r_row_shown;
    assign o_dest_row     = r_dest_row;
    assign o_mask_out     = r_mask_out;
    assign o_image_out    = r_image_out;
    assign o_clip_left    = r_clip_left;
    assign o_clip_top     = r_clip_top;
    assign o_first_column = r_first_column;
    assign o_columns_used = r_columns_used;
    assign o_rows_used    = r_rows_used;

    // ---------------- assertions ----------------
    // each taken request comes out on o_valid
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid)
        else $error("request lost in pipeline");

    // a refused call leaves no area and no bytes behind
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_accepted) |-> (o_rows_used == 5'd0 && o_clip_left == 15'd0 &&
            o_mask_out == 24'd0 && !o_row_shown))
        else $error("refused call reports data");

    // image bits only under set mask bits
    a_image_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_image_out & ~o_mask_out) == 24'd0))
        else $error("image bit outside mask");

    // first byte column follows the clipped left edge; columns and rows used are nonzero
    a_first_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_accepted) |-> (o_first_column == o_clip_left[14:3] &&
            o_columns_used != 2'd0 && o_rows_used != 5'd0))
        else $error("saved area inconsistent");

endmodule

### tb/sv/tb_crma_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_crma_check_pkg: expected-row store and comparison for the cursor aligner
// Holds the request and result layouts, a copy of the screen resolution and
// the scoreboard that predicts the clipped area and the byte-aligned row for
// each taken request and compares each result field by field.
// ----------------------------------------------------------------------------
package tb_crma_check_pkg;

    import crma_pkg::*;

    localparam int ROW_BYTE_LIMIT = 3;
    localparam int REPORT_LINES   = 50;

    // one row request as driven on the input ports
    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [15:0]      shape_width;
        logic [15:0]      shape_height;
        logic [3:0]       row_number;
        logic [SRC_W-1:0] mask_row;
        logic [SRC_W-1:0] image_row;
    } row_request_t;

    // one result, same order as the result ports
    typedef struct packed {
        logic             accepted;
        logic             row_shown;
        logic [3:0]       dest_row;
        logic [OUT_W-1:0] mask_out;
        logic [OUT_W-1:0] image_out;
        logic [RES_W-1:0] clip_left;
        logic [RES_W-1:0] clip_top;
        logic [11:0]      first_column;
        logic [1:0]       columns_used;
        logic [4:0]       rows_used;
    } row_result_t;

    class cursor_row_checker;

        logic [RES_W-1:0] scr_wide;
        logic [RES_W-1:0] scr_high;
        row_result_t      pending_rows[$];
        int               errors;
        int               n_requests;
        int               n_valid;
        int               n_drawn;
        int               n_checked;

        function new();
            scr_wide = WIDE_RESET;
            scr_high = HIGH_RESET;
        endfunction

        function void set_register(t_reg_idx idx, logic [RES_W-1:0] value);
            case (idx)
                REG_WIDE: begin
                    scr_wide = value;
                end
                REG_HIGH: begin
                    scr_high = value;
                end
                default: begin
                end
            endcase
        endfunction

        function int pending();
            return pending_rows.size();
        endfunction

        // clip the 16x16 square to the screen and place one row into bytes
        function row_result_t align_row(row_request_t rq);
            row_result_t rs;
            int x, y, xres, yres, left, top, right, bottom;
            int first, nbytes, nrows, src0, sx, ofs, rn;
            rs   = '0;
            x    = int'($signed(rq.pos_x));
            y    = int'($signed(rq.pos_y));
            xres = int'(scr_wide);
            yres = int'(scr_high);
            rn   = int'(rq.row_number);
            if (rq.shape_width != 16'(CURSOR_SIZE) || rq.shape_height != 16'(CURSOR_SIZE))
                return rs;
            if (x < 1 - CURSOR_SIZE || y < 1 - CURSOR_SIZE || x >= xres || y >= yres)
                return rs;
            left   = (x < 0) ? 0 : x;
            top    = (y < 0) ? 0 : y;
            right  = x + CURSOR_SIZE - 1;
            bottom = y + CURSOR_SIZE - 1;
            if (right >= xres)
                right = xres - 1;
            if (bottom >= yres)
                bottom = yres - 1;
            if (right < left || bottom < top)
                return rs;
            first  = left / 8;
            nbytes = right / 8 - first + 1;
            nrows  = bottom - top + 1;
            if (nbytes > ROW_BYTE_LIMIT || nrows > CURSOR_SIZE)
                return rs;
            rs.accepted     = 1'b1;
            rs.clip_left    = left[RES_W-1:0];
            rs.clip_top     = top[RES_W-1:0];
            rs.first_column = first[11:0];
            rs.columns_used = nbytes[1:0];
            rs.rows_used    = nrows[4:0];
            // rows above the screen are skipped, rows past the bottom are hidden
            src0 = top - y;
            if (rn < src0 || rn >= src0 + nrows)
                return rs;
            rs.row_shown = 1'b1;
            rs.dest_row  = 4'(rn - src0);
            // source bit 15 is the leftmost pixel; drop what is off screen
            for (int c = 0; c < CURSOR_SIZE; c++) begin
                sx = x + c;
                if (sx < 0)
                    continue;
                if (sx >= xres)
                    break;
                ofs = sx - 8 * first;
                if (ofs < 0 || ofs > 23)
                    continue;
                if (rq.mask_row[15-c]) begin
                    rs.mask_out[23-ofs] = 1'b1;
                    if (rq.image_row[15-c])
                        rs.image_out[23-ofs] = 1'b1;
                end
            end
            return rs;
        endfunction

        function void note_request(row_request_t rq);
            row_result_t rs;
            rs = align_row(rq);
            pending_rows.push_back(rs);
            n_requests++;
            if (rs.accepted)
                n_valid++;
            if (rs.row_shown)
                n_drawn++;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= REPORT_LINES)
                $display("mismatch: %s", msg);
        endtask

        task check_field(string name, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
            if (got !== want)
                report($sformatf("result %0d %s: got %h, expected %h",
                                 n_checked, name, got, want));
        endtask

        task check_result(row_result_t got);
            row_result_t want;
            if (pending_rows.size() == 0) begin
                report($sformatf("result %0d arrived with no request outstanding",
                                 n_checked));
                n_checked++;
                return;
            end
            want = pending_rows.pop_front();
            check_field("accepted", OUT_W'(got.accepted), OUT_W'(want.accepted));
            check_field("row_shown", OUT_W'(got.row_shown), OUT_W'(want.row_shown));
            check_field("dest_row", OUT_W'(got.dest_row), OUT_W'(want.dest_row));
            check_field("mask_out", got.mask_out, want.mask_out);
            check_field("image_out", got.image_out, want.image_out);
            check_field("clip_left", OUT_W'(got.clip_left), OUT_W'(want.clip_left));
            check_field("clip_top", OUT_W'(got.clip_top), OUT_W'(want.clip_top));
            check_field("first_column", OUT_W'(got.first_column),
                        OUT_W'(want.first_column));
            check_field("columns_used", OUT_W'(got.columns_used),
                        OUT_W'(want.columns_used));
            check_field("rows_used", OUT_W'(got.rows_used), OUT_W'(want.rows_used));
            n_checked++;
        endtask

    endclass

endpackage

### tb/sv/tb_cursor_row_mask_aligner.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cursor_row_mask_aligner: self-checking bench for the cursor row aligner
// Drives directed edge cases and then random cursor rows over a series of
// screen resolutions, with and without gaps between requests, and checks
// every result against a predicted clip area and byte-aligned row.
// ----------------------------------------------------------------------------
module tb_cursor_row_mask_aligner;

    import crma_pkg::*;
    import tb_crma_check_pkg::*;

    localparam int STALL_LIMIT = 200;
    localparam int NUM_PHASES  = 9;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [POS_W-1:0]      i_pos_x;
    logic [POS_W-1:0]      i_pos_y;
    logic [15:0]           i_shape_width;
    logic [15:0]           i_shape_height;
    logic [3:0]            i_row_number;
    logic [SRC_W-1:0]      i_cursor_mask_row;
    logic [SRC_W-1:0]      i_cursor_image_row;
    logic                  i_cfg_we;
    logic [0:0]            i_cfg_idx;
    logic [RES_W-1:0]      i_cfg_data;
    logic                  o_valid;
    logic                  o_accepted;
    logic                  o_row_shown;
    logic [3:0]            o_dest_row;
    logic [OUT_W-1:0]      o_mask_out;
    logic [OUT_W-1:0]      o_image_out;
    logic [RES_W-1:0]      o_clip_left;
    logic [RES_W-1:0]      o_clip_top;
    logic [11:0]           o_first_column;
    logic [1:0]            o_columns_used;
    logic [4:0]            o_rows_used;

    cursor_row_checker rows_chk;
    int                cur_wide;
    int                cur_high;
    int                quiet_cycles;
    int                n_settings;
    int                phase_items[NUM_PHASES] = '{80, 60, 80, 40, 40, 90, 90, 90, 80};

    cursor_row_mask_aligner i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_pos_x            (i_pos_x),
        .i_pos_y            (i_pos_y),
        .i_shape_width      (i_shape_width),
        .i_shape_height     (i_shape_height),
        .i_row_number       (i_row_number),
        .i_cursor_mask_row  (i_cursor_mask_row),
        .i_cursor_image_row (i_cursor_image_row),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .o_valid            (o_valid),
        .o_accepted         (o_accepted),
        .o_row_shown        (o_row_shown),
        .o_dest_row         (o_dest_row),
        .o_mask_out         (o_mask_out),
        .o_image_out        (o_image_out),
        .o_clip_left        (o_clip_left),
        .o_clip_top         (o_clip_top),
        .o_first_column     (o_first_column),
        .o_columns_used     (o_columns_used),
        .o_rows_used        (o_rows_used)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result monitor: every strobe is checked against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            rows_chk.check_result({o_accepted, o_row_shown, o_dest_row, o_mask_out,
                                   o_image_out, o_clip_left, o_clip_top,
                                   o_first_column, o_columns_used, o_rows_used});
    end

    // watchdog: too long with neither a request taken nor a result seen
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // present one request at the falling edge and hold it until taken
    task automatic send_request(row_request_t rq);
        @(negedge i_clk);
        i_pos_x            <= rq.pos_x;
        i_pos_y            <= rq.pos_y;
        i_shape_width      <= rq.shape_width;
        i_shape_height     <= rq.shape_height;
        i_row_number       <= rq.row_number;
        i_cursor_mask_row  <= rq.mask_row;
        i_cursor_image_row <= rq.image_row;
        start              <= 1'b1;
        do
            @(posedge i_clk);
        while (busy);
        rows_chk.note_request(rq);
    endtask

    task automatic send_row(int x, int y, int w, int h, int rn, int m, int im);
        row_request_t rq;
        rq.pos_x        = x[15:0];
        rq.pos_y        = y[15:0];
        rq.shape_width  = w[15:0];
        rq.shape_height = h[15:0];
        rq.row_number   = rn[3:0];
        rq.mask_row     = m[15:0];
        rq.image_row    = im[15:0];
        send_request(rq);
    endtask

    // stop requesting and wait for every outstanding result
    task automatic drain_requests();
        @(negedge i_clk) start <= 1'b0;
        while (rows_chk.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_screen(t_reg_idx idx, int value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[RES_W-1:0];
        @(posedge i_clk);
        rows_chk.set_register(idx, value[RES_W-1:0]);
        @(negedge i_clk) i_cfg_we <= 1'b0;
        if (idx == REG_WIDE)
            cur_wide = value;
        else
            cur_high = value;
    endtask

    // coordinate biased toward the low edge, the high edge or anywhere
    function automatic int pick_coord(int res);
        int lo, hi, base;
        if (res == 0)
            return int'($urandom_range(30)) - 15;
        lo = 1 - CURSOR_SIZE;
        hi = res;
        case ($urandom_range(3))
            0: begin
                base = (hi < 8) ? hi : 8;
                return lo + int'($urandom_range(base - lo));
            end
            1: begin
                base = (res - 17 > lo) ? res - 17 : lo;
                return base + int'($urandom_range(hi - base));
            end
            default: begin
                return lo + int'($urandom_range(hi - lo));
            end
        endcase
    endfunction

    function automatic logic [15:0] pick_bits();
        case ($urandom_range(7))
            0:       return 16'hFFFF;
            1:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        row_request_t rq;
        int           idle_pct;
        int           sel;
        rows_chk           = new();
        cur_wide           = int'(WIDE_RESET);
        cur_high           = int'(HIGH_RESET);
        n_settings         = 1;
        quiet_cycles       = 0;
        i_rst_n            = 1'b0;
        start              = 1'b0;
        i_pos_x            = '0;
        i_pos_y            = '0;
        i_shape_width      = '0;
        i_shape_height     = '0;
        i_row_number       = '0;
        i_cursor_mask_row  = '0;
        i_cursor_image_row = '0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed rows at the reset resolution of 640x480
        send_row(0, 0, 16, 16, 0, 'hFFFF, 'hFFFF);
        send_row(0, 0, 16, 16, 15, 'h8001, 'h0001);
        send_row(0, 0, 15, 16, 0, 'hFFFF, 'hFFFF);          // wrong width
        send_row(0, 0, 16, 17, 0, 'hFFFF, 'hFFFF);          // wrong height
        send_row(0, 0, 0, 0, 3, 'hFFFF, 'hFFFF);
        send_row(0, 0, 'hFFFF, 'hFFFF, 3, 'hFFFF, 'hFFFF);
        send_row(-15, -15, 16, 16, 15, 'hFFFF, 'hAAAA);     // one pixel left in corner
        send_row(-15, -15, 16, 16, 14, 'hFFFF, 'hAAAA);     // row above the screen
        send_row(-16, 0, 16, 16, 0, 'hFFFF, 'hFFFF);        // too far left
        send_row(0, -16, 16, 16, 0, 'hFFFF, 'hFFFF);        // too far up
        send_row(-32768, -32768, 16, 16, 0, 'hFFFF, 'hFFFF);
        send_row(32767, 32767, 16, 16, 0, 'hFFFF, 'hFFFF);
        send_row(639, 479, 16, 16, 0, 'hFFFF, 'h5555);      // last pixel on screen
        send_row(639, 479, 16, 16, 1, 'hFFFF, 'h5555);      // row past the bottom
        send_row(640, 0, 16, 16, 0, 'hFFFF, 'hFFFF);        // at the right edge
        send_row(0, 480, 16, 16, 0, 'hFFFF, 'hFFFF);        // at the bottom edge
        send_row(3, 5, 16, 16, 7, 'hFFFF, 'hFFFF);          // spans three bytes
        send_row(8, 100, 16, 16, 3, 'h0000, 'hFFFF);        // image without mask
        send_row(630, 470, 16, 16, 9, 'hF0F1, 'h3C3C);      // clipped right and bottom
        send_row(630, 470, 16, 16, 12, 'hF0F1, 'h3C3C);
        send_row(-7, -3, 16, 16, 2, 'hFFFF, 'h1234);
        send_row(-7, -3, 16, 16, 3, 'hFFFF, 'h1234);
        send_row(-1, 0, 16, 16, 4, 'h8000, 'h8000);         // only bit dropped left

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // new resolution only once the pipeline has emptied
            if (ph != 0) begin
                drain_requests();
                case (ph)
                    1: begin
                        write_screen(REG_WIDE, 1);
                        write_screen(REG_HIGH, 1);
                    end
                    2: begin
                        write_screen(REG_WIDE, 32767);
                        write_screen(REG_HIGH, 32767);
                    end
                    3: begin
                        write_screen(REG_WIDE, 0);
                        write_screen(REG_HIGH, 480);
                    end
                    4: begin
                        write_screen(REG_WIDE, 640);
                        write_screen(REG_HIGH, 0);
                    end
                    5: begin
                        write_screen(REG_WIDE, 20);
                        write_screen(REG_HIGH, 12);
                    end
                    6: begin
                        write_screen(REG_WIDE, int'($urandom_range(32767, 1)));
                        write_screen(REG_HIGH, int'($urandom_range(32767, 1)));
                    end
                    7: begin
                        write_screen(REG_WIDE, int'($urandom_range(200, 9)));
                        write_screen(REG_HIGH, int'($urandom_range(200, 1)));
                    end
                    default: begin
                        write_screen(REG_WIDE, 640);
                        write_screen(REG_HIGH, 480);
                    end
                endcase
                n_settings++;
            end
            case (ph % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 69;
                default: idle_pct = 26;
            endcase

            for (int n = 0; n < phase_items[ph]; n++) begin
                sel = $urandom_range(99);
                if (sel < 75) begin
                    // well-formed cursor near the screen, random row content
                    rq.pos_x        = 16'(pick_coord(cur_wide));
                    rq.pos_y        = 16'(pick_coord(cur_high));
                    rq.shape_width  = 16'(CURSOR_SIZE);
                    rq.shape_height = 16'(CURSOR_SIZE);
                end else begin
                    // noise: wild or near positions, often with broken shape sizes
                    rq.pos_x        = 16'($urandom);
                    rq.pos_y        = 16'($urandom);
                    rq.shape_width  = 16'(CURSOR_SIZE);
                    rq.shape_height = 16'(CURSOR_SIZE);
                    if (sel >= 90) begin
                        rq.pos_x = 16'(pick_coord(cur_wide));
                        rq.pos_y = 16'(pick_coord(cur_high));
                    end
                    case ($urandom_range(3))
                        1: rq.shape_height = 16'($urandom);
                        2: rq.shape_width  = 16'($urandom);
                        3: begin
                            rq.shape_width  = 16'($urandom);
                            rq.shape_height = 16'($urandom);
                        end
                        default: begin
                        end
                    endcase
                end
                rq.row_number = 4'($urandom_range(15));
                rq.mask_row   = pick_bits();
                rq.image_row  = pick_bits();
                send_request(rq);
                if ($urandom_range(99) < idle_pct) begin
                    @(negedge i_clk) start <= 1'b0;
                    repeat ($urandom_range(3)) @(negedge i_clk);
                end
            end
        end

        drain_requests();
        repeat (8) @(posedge i_clk);

        $display("run covered %0d requests over %0d screen settings", rows_chk.n_requests,
                 n_settings);
        $display("%0d in bounds, %0d rows drawn, %0d refused, %0d mismatches",
                 rows_chk.n_valid, rows_chk.n_drawn,
                 rows_chk.n_requests - rows_chk.n_valid, rows_chk.errors);
        if (rows_chk.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
